// ===== rtl/swmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared widths, state encodings and control types of the sliding window
// max/min spread block.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int SAMPLE_W = 32;   // sample width, two's complement
  localparam int SPREAD_W = 32;   // result width, unsigned
  localparam int CFG_W    = 11;   // window length register width

  // queue unit sequencer
  typedef enum logic [1:0] {
    Q_IDLE,
    Q_FCHK,   // checking front entry for expiry
    Q_BCHK,   // checking back entry for domination
    Q_PUSH
  } swmm_qstate_e;

  // top level sequencer
  typedef enum logic [1:0] {
    T_IDLE,
    T_WAIT,
    T_UPD
  } swmm_tstate_e;

  // control from top level to a queue unit
  typedef struct packed {
    logic start;  // process the held sample
    logic flush;  // empty the queue for a new stream
  } swmm_ctl_t;

endpackage

// ===== rtl/swmm_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm interfaces
// Valid/ready channels for samples, results and window length writes.
// ----------------------------------------------------------------------------
interface swmm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [swmm_pkg::SAMPLE_W-1:0]  sample;
  logic                                  is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink   (input valid, input sample, input is_last, output ready);
endinterface

interface swmm_out_if;
  logic                          valid;
  logic                          ready;
  logic [swmm_pkg::SPREAD_W-1:0] best_spread;

  modport source (output valid, output best_spread, input ready);
  modport sink   (input valid, input best_spread, output ready);
endinterface

interface swmm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [swmm_pkg::CFG_W-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

// ===== rtl/swmm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_queue
// Monotonic maximum queue in a ring memory. Each entry holds the ring slot
// and the value of a sample. Feed inverted samples to track a minimum.
// ----------------------------------------------------------------------------
module swmm_queue #(
  parameter int MaxWindow = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swmm_pkg::swmm_ctl_t           ctl_i,
  input  logic [$clog2(MaxWindow)-1:0]  pos_i,
  input  logic [$clog2(MaxWindow+1)-1:0] win_i,
  input  logic [swmm_pkg::SAMPLE_W-1:0] x_i,
  output logic                          done_o,
  output logic [swmm_pkg::SAMPLE_W-1:0] head_o
);

  localparam int AW = $clog2(MaxWindow);
  localparam int CW = $clog2(MaxWindow + 1);
  localparam int DW = AW + 1;
  localparam int EW = AW + swmm_pkg::SAMPLE_W;
  localparam logic [AW-1:0] LastIdx = AW'(MaxWindow - 1);
  localparam logic [DW-1:0] Depth   = DW'(MaxWindow);

  logic [EW-1:0] mem [MaxWindow];

  swmm_pkg::swmm_qstate_e state_q, state_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [swmm_pkg::SAMPLE_W-1:0] hv_q, hv_d;
  logic [EW-1:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  logic [AW-1:0] rslot;
  logic [swmm_pkg::SAMPLE_W-1:0] rval;
  logic [DW-1:0] diff, age;
  logic          expire, dominated;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == LastIdx) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? LastIdx : p - AW'(1);
  endfunction

  assign rslot = rdata_q[EW-1 -: AW];
  assign rval  = rdata_q[swmm_pkg::SAMPLE_W-1:0];

  // age of the entry just read; zero distance means a full ring
  always_comb begin
    if (pos_i >= rslot) begin
      diff = DW'(pos_i) - DW'(rslot);
    end else begin
      diff = DW'(pos_i) + Depth - DW'(rslot);
    end
    age = (diff == '0) ? Depth : diff;
  end

  assign expire    = (age >= DW'(win_i));
  assign dominated = ($signed(rval) <= $signed(x_i));

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    hv_d    = hv_q;
    rd_addr = head_q;
    wr_en   = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      swmm_pkg::Q_IDLE: begin
        if (ctl_i.flush) begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = '0;
        end else if (ctl_i.start) begin
          state_d = (cnt_q != '0) ? swmm_pkg::Q_FCHK : swmm_pkg::Q_PUSH;
        end
      end
      swmm_pkg::Q_FCHK: begin
        if (expire) begin
          head_d = ring_next(head_q);
          cnt_d  = cnt_q - CW'(1);
          if (cnt_q > CW'(1)) begin
            rd_addr = ring_next(head_q);
          end else begin
            state_d = swmm_pkg::Q_PUSH;
          end
        end else begin
          // surviving front is the window max unless popped from the back
          hv_d    = rval;
          rd_addr = ring_prev(tail_q);
          state_d = swmm_pkg::Q_BCHK;
        end
      end
      swmm_pkg::Q_BCHK: begin
        if (dominated) begin
          tail_d = ring_prev(tail_q);
          cnt_d  = cnt_q - CW'(1);
          if (cnt_q > CW'(1)) begin
            rd_addr = ring_prev(ring_prev(tail_q));
          end else begin
            state_d = swmm_pkg::Q_PUSH;
          end
        end else begin
          state_d = swmm_pkg::Q_PUSH;
        end
      end
      swmm_pkg::Q_PUSH: begin
        wr_en  = 1'b1;
        tail_d = ring_next(tail_q);
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == '0) begin
          hv_d = x_i;
        end
        done_o  = 1'b1;
        state_d = swmm_pkg::Q_IDLE;
      end
      default: begin
        state_d = swmm_pkg::Q_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= {pos_i, x_i};
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swmm_pkg::Q_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hv_q <= hv_d;
  end

  assign head_o = hv_q;

endmodule

// ===== rtl/sliding_window_max_min_spread.sv =====
`timescale 1ns / 1ps
// Flow: an accepted sample starts both queue units, which expire old entries
//   from the front, pop dominated entries from the back, then push the sample.
// Flow control: one sample in flight; the input is ready only while the
//   sequencer idles, so the next sample waits for both queues and the update.
// Reset: asynchronous, active low; empties both queues, clears the running
//   best, sets the window length to 1. Queue memories are not cleared.
// ----------------------------------------------------------------------------
// sliding_window_max_min_spread
// Greatest (window max - window min) over a stream of signed samples,
// reported on the beat marked last.
// ----------------------------------------------------------------------------
module sliding_window_max_min_spread #(
  parameter int MaxWindow = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swmm_in_if.sink    in_i,
  swmm_out_if.source out_o,
  swmm_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(MaxWindow);
  localparam int CW = $clog2(MaxWindow + 1);
  localparam logic [AW-1:0] LastIdx = AW'(MaxWindow - 1);

  // --------------------------------------------------------------------------
  // Window length register; zero means 1, values beyond the ring saturate.
  // --------------------------------------------------------------------------
  logic [swmm_pkg::CFG_W-1:0] wlen_q;
  logic [CW-1:0]              win;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= swmm_pkg::CFG_W'(1);
    end else if (cfg_i.valid) begin
      wlen_q <= cfg_i.window_length;
    end
  end

  always_comb begin
    if (wlen_q == '0) begin
      win = CW'(1);
    end else if (32'(wlen_q) > 32'(MaxWindow)) begin
      win = CW'(MaxWindow);
    end else begin
      win = CW'(wlen_q);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  swmm_pkg::swmm_tstate_e state_q, state_d;
  logic [AW-1:0]                 pos_q, pos_d;      // ring slot of this sample
  logic [swmm_pkg::SPREAD_W-1:0] best_q, best_d;    // running best of stream
  logic [swmm_pkg::SAMPLE_W-1:0] x_q;
  logic                          last_q;
  logic [1:0]                    done_q, done_d;    // {max, min} finished
  logic                          ovalid_q, ovalid_d;
  logic [swmm_pkg::SPREAD_W-1:0] odata_q, odata_d;

  logic                          accept;
  swmm_pkg::swmm_ctl_t           ctl;
  logic                          done_max, done_min;
  logic [swmm_pkg::SAMPLE_W-1:0] hi, lo_n;
  logic [swmm_pkg::SPREAD_W-1:0] spread, new_best;
  logic [1:0]                    done_seen;

  assign in_i.ready = (state_q == swmm_pkg::T_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // Queue units. The min queue runs as a max queue on inverted samples:
  // bitwise NOT reverses signed order, so its head is ~min.
  // --------------------------------------------------------------------------
  swmm_queue #(
    .MaxWindow (MaxWindow)
  ) u_max_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .pos_i  (pos_q),
    .win_i  (win),
    .x_i    (x_q),
    .done_o (done_max),
    .head_o (hi)
  );

  swmm_queue #(
    .MaxWindow (MaxWindow)
  ) u_min_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .pos_i  (pos_q),
    .win_i  (win),
    .x_i    (~x_q),
    .done_o (done_min),
    .head_o (lo_n)
  );

  // spread wraps modulo 2^32, matching an unsigned subtract
  assign spread    = hi - ~lo_n;
  assign new_best  = (spread > best_q) ? spread : best_q;
  assign done_seen = done_q | {done_max, done_min};

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    best_d    = best_q;
    done_d    = done_q;
    ovalid_d  = ovalid_q;
    odata_d   = odata_q;
    ctl.start = 1'b0;
    ctl.flush = 1'b0;

    // result register drains independently of the sample side
    if (out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      swmm_pkg::T_IDLE: begin
        if (accept) begin
          ctl.start = 1'b1;
          done_d    = 2'b00;
          state_d   = swmm_pkg::T_WAIT;
        end
      end
      swmm_pkg::T_WAIT: begin
        done_d = done_seen;
        if (&done_seen) begin
          state_d = swmm_pkg::T_UPD;
        end
      end
      swmm_pkg::T_UPD: begin
        if (!last_q) begin
          best_d  = new_best;
          pos_d   = (pos_q == LastIdx) ? '0 : pos_q + AW'(1);
          state_d = swmm_pkg::T_IDLE;
        end else if (!ovalid_q || out_o.ready) begin
          // end of stream: hand out the result and start afresh
          ovalid_d  = 1'b1;
          odata_d   = new_best;
          best_d    = '0;
          pos_d     = '0;
          ctl.flush = 1'b1;
          state_d   = swmm_pkg::T_IDLE;
        end
      end
      default: begin
        state_d = swmm_pkg::T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swmm_pkg::T_IDLE;
      pos_q    <= '0;
      best_q   <= '0;
      done_q   <= 2'b00;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      best_q   <= best_d;
      done_q   <= done_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    if (accept) begin
      x_q    <= in_i.sample;
      last_q <= in_i.is_last;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.best_spread = odata_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sliding_window_max_min_spread. A behavioural
// predictor keeps its own max/min tracking queues, works out the best spread
// of every stream, and a monitor compares each result beat with the oldest
// prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WINDOW_DEPTH = 1024;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  // Settle time for the slowest sample, one that drops up to a full queue's
  // worth of entries; used as the settle time before a window write.
  localparam int POST_LATENCY = 1200;
  localparam int HOLD_SPAN    = 300;     // long receiver hold-off, in cycles
  localparam int STALL_LIMIT  = 20000;   // cycles with no beat on any channel
  localparam int REPORT_MAX   = 10;

  typedef logic signed [swmm_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic        [swmm_pkg::SPREAD_W-1:0] spread_t;
  typedef logic        [swmm_pkg::CFG_W-1:0]    wlen_t;

  // one tracked window entry: ring slot and the sample held there
  typedef struct {
    logic [SLOT_W-1:0] slot;
    sample_t           value;
  } tracked_t;

  logic clk_i;
  logic rst_ni;

  swmm_in_if  in_if ();
  swmm_out_if out_if ();
  swmm_cfg_if cfg_if ();

  sliding_window_max_min_spread u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the window register and of the two
  // monotonic queues. peak_track holds candidates for the window maximum
  // (values strictly falling from the front), trough_track those for the
  // minimum (strictly rising).
  // --------------------------------------------------------------------------
  tracked_t          peak_track[$];
  tracked_t          trough_track[$];
  logic [SLOT_W-1:0] next_slot;
  spread_t           stream_best;
  wlen_t             window_reg;

  spread_t spread_due[$];    // best spreads still to come out, oldest first

  // run statistics
  int n_samples;
  int n_streams;
  int n_checked;
  int n_window_writes;
  int err_count;

  // shared controls between the stimulus and the receiver
  bit steady_flow;           // no random idling on either side while set
  int hold_asks;             // bumped by a test to ask for a long hold-off
  int hold_seen;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Age of a tracked slot relative to the next slot; a zero distance can only
  // mean a full lap of the ring.
  function automatic int unsigned slot_age(logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] gap;
    gap = next_slot - slot;
    return (gap == '0) ? WINDOW_DEPTH : int'(gap);
  endfunction

  // Advance the predictor by one accepted sample beat.
  task automatic predict_spread(input sample_t s, input logic last);
    int unsigned span;
    spread_t     spread;
    tracked_t    entry;
    span = window_reg;
    if (span == 0) span = 1;
    if (span > WINDOW_DEPTH) span = WINDOW_DEPTH;
    // expire from the front
    while (peak_track.size() > 0 && slot_age(peak_track[0].slot) >= span)
      void'(peak_track.pop_front());
    while (trough_track.size() > 0 && slot_age(trough_track[0].slot) >= span)
      void'(trough_track.pop_front());
    // dominated entries leave from the back; ties are dropped too
    while (peak_track.size() > 0 && peak_track[$].value <= s)
      void'(peak_track.pop_back());
    while (trough_track.size() > 0 && trough_track[$].value >= s)
      void'(trough_track.pop_back());
    entry.slot  = next_slot;
    entry.value = s;
    peak_track.push_back(entry);
    trough_track.push_back(entry);
    next_slot = next_slot + 1'b1;
    // unsigned difference, wraps to the full 32-bit range
    spread = spread_t'(peak_track[0].value) - spread_t'(trough_track[0].value);
    if (spread > stream_best) stream_best = spread;
    if (last) begin
      spread_due.push_back(stream_best);
      peak_track.delete();
      trough_track.delete();
      next_slot   = '0;
      stream_best = '0;
      n_streams++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sample sender. Called in step with the clock; returns once the accepting
  // handshake is seen, with valid still asserted, so the next call either
  // offers the next beat or opens a gap with a single assignment.
  // --------------------------------------------------------------------------
  task automatic send_sample(input sample_t s, input logic last);
    while (!steady_flow && $urandom_range(99) < 27) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.sample  <= s;
    in_if.is_last <= last;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    n_samples++;
    predict_spread(s, last);
  endtask

  // Sender pauses until every predicted result has come out.
  task automatic wait_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (spread_due.size() != 0);
  endtask

  // Window writes only land on an idle block: drain, then let a worst-case
  // sample finish, since a beat without a result may still be in flight.
  task automatic write_window(input wlen_t len);
    wait_results();
    repeat (POST_LATENCY) @(posedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= len;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    window_reg = len;
    n_window_writes++;
  endtask

  // Mix of extremes, tie-prone small values and full-range noise.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return {1'b1, {(swmm_pkg::SAMPLE_W-1){1'b0}}};
      1:       return {1'b0, {(swmm_pkg::SAMPLE_W-1){1'b1}}};
      2, 3, 4: return sample_t'(int'($urandom_range(6)) - 3);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Stream of random samples, the final one marked last.
  task automatic send_stream(input int len);
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(), i == len - 1);
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Field extremes, window register corner values and a resize mid-stream.
  task automatic test_directed();
    // window is 1 out of reset; a lone sample gives a zero spread
    send_sample({1'b0, {(swmm_pkg::SAMPLE_W-1){1'b1}}}, 1'b1);

    // most negative next to most positive: full 32-bit spread
    write_window(wlen_t'(4));
    send_sample({1'b1, {(swmm_pkg::SAMPLE_W-1){1'b0}}}, 1'b0);
    send_sample({1'b0, {(swmm_pkg::SAMPLE_W-1){1'b1}}}, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1, 1'b1);

    // zero length behaves as one
    write_window('0);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    send_sample(100, 1'b1);

    // all-ones register saturates to the full window; equal values
    write_window('1);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(7, 1'b0);
    send_sample(-3, 1'b1);

    // shrink then enlarge inside one stream: dropped samples stay dropped
    write_window(wlen_t'(3));
    send_sample(10, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    write_window(wlen_t'(1));
    send_sample(0, 1'b0);
    write_window(wlen_t'(8));
    send_sample(2, 1'b1);
  endtask

  // Short random streams under a spread of window settings.
  task automatic test_window_sweep();
    wlen_t settings[11];
    int    sent;
    int    len;
    settings = '{wlen_t'(1), wlen_t'(2), wlen_t'(3), wlen_t'(7), wlen_t'(16),
                 wlen_t'(64), wlen_t'(1024), wlen_t'(1025), '1, '0,
                 wlen_t'($urandom_range(1, 2047))};
    foreach (settings[k]) begin
      write_window(settings[k]);
      sent = 0;
      while (sent < 2) begin
        len = int'($urandom_range(1, 4));
        send_stream(len);
        sent += len;
      end
    end
  endtask

  // Window register rewritten between beats of one stream.
  task automatic test_mid_stream_resize();
    int len;
    for (int r = 0; r < 2; r++) begin
      write_window(wlen_t'($urandom_range(1, 20)));
      len = int'($urandom_range(3, 10));
      for (int i = 0; i < len; i++) send_sample(pick_sample(), 1'b0);
      case ($urandom_range(2))
        0:       write_window(wlen_t'(1));
        1:       write_window(wlen_t'(WINDOW_DEPTH));
        default: write_window(wlen_t'($urandom_range(1, 30)));
      endcase
      send_stream(int'($urandom_range(1, 6)));
    end
  endtask

  // One stream longer than the ring at full window, drifting downwards so
  // that old maxima age out a full lap later. Starts with a stretch of
  // back-to-back beats on both sides.
  task automatic test_ring_wrap();
    int walk;
    int len;
    write_window(wlen_t'(WINDOW_DEPTH));
    walk = $urandom;
    len  = WINDOW_DEPTH + 6;
    steady_flow = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (i == 250) steady_flow = 1'b0;
      walk = walk + int'($urandom_range(40)) - 28;
      if ($urandom_range(49) == 0) walk = $urandom;
      send_sample(sample_t'(walk), i == len - 1);
    end
  endtask

  // Receiver held off while the sender keeps offering short streams, so a
  // result backs up and the input stalls; then the sender drains.
  task automatic test_output_stall();
    write_window(wlen_t'($urandom_range(1, 5)));
    hold_asks++;
    steady_flow = 1'b1;
    for (int s = 0; s < 6; s++) send_stream(2);
    steady_flow = 1'b0;
    wait_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold-off when a test asks for one.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_asks != hold_seen) begin
        hold_seen++;
        hold_left = HOLD_SPAN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady_flow || ($urandom_range(99) >= 27);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every result beat is matched against the oldest
  // prediction; values are read before this edge's updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    spread_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      if (spread_due.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("unexpected result beat: best_spread=%0d", out_if.best_spread);
      end else begin
        want = spread_due.pop_front();
        n_checked++;
        if (out_if.best_spread !== want) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("best_spread mismatch: expected %0d, got %0d",
                     want, out_if.best_spread);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run if no beat moves on any channel for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid === 1'b1 && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.sample         <= '0;
    in_if.is_last        <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.window_length <= '0;
    window_reg  = wlen_t'(1);
    next_slot   = '0;
    stream_best = '0;
    steady_flow = 1'b0;
    hold_asks   = 0;
    hold_seen   = 0;
    n_samples       = 0;
    n_streams       = 0;
    n_checked       = 0;
    n_window_writes = 0;
    err_count       = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_window_sweep();
    test_mid_stream_resize();
    test_ring_wrap();
    test_output_stall();

    // all stimulus in; wait for the tail, then give a stray beat time to show
    wait_results();
    repeat (POST_LATENCY) @(posedge clk_i);

    $display("covered %0d samples in %0d streams, %0d results checked, %0d window writes",
             n_samples, n_streams, n_checked, n_window_writes);
    $display("windows 0..2047 incl. saturation, mid-stream resize, ring wrap, output hold-off");
    if (err_count == 0 && spread_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", err_count, spread_due.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
